### hdl/fbsr_pkg.sv
// Shared constants and types of the scaled framebuffer readout.
`timescale 1ns / 1ps

package fbsr_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned SIZE_W     = 9;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned COLOR_W    = 32;

  localparam int unsigned OUT_SIZE_MAX = 256;

  localparam logic [SIZE_W-1:0]  SIZE_RST  = SIZE_W'(256);
  localparam logic [COLOR_W-1:0] COLOR_RST = '0;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FB_WIDTH   = 3'd0,
    CFG_FB_HEIGHT  = 3'd1,
    CFG_OUT_WIDTH  = 3'd2,
    CFG_OUT_HEIGHT = 3'd3,
    CFG_CLEAR      = 3'd4,
    CFG_SWAP       = 3'd5
  } cfg_idx_e;

endpackage

### hdl/fbsr_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module fbsr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/fbsr_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module fbsr_div #(
  parameter int unsigned DividendW = 17,
  parameter int unsigned DivisorW  = 9
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 done_o,
  output logic [DividendW-1:0] quotient_o,
  output logic [DivisorW-1:0]  remainder_o
);

  localparam int unsigned CntW = $clog2(DividendW + 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DivisorW-1:0]  dsr_q, dsr_d;
  logic [DivisorW:0]    trial;
  logic                 fits;

  assign trial = {rem_q, quo_q[DividendW-1]};
  assign fits  = (trial >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DividendW);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? DivisorW'(trial - {1'b0, dsr_q}) : trial[DivisorW-1:0];
      quo_d = {quo_q[DividendW-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

### hdl/framebuffer_scaled_readout.sv
// Top level: pixel store with clear, coordinate write and nearest-neighbor scaled readout.
//
//   port group  direction  transfer when          carries
//   cfg         in         cfg_we_i               cfg_idx_i, cfg_data_i
//   in          in         in_valid_i & ready     command_i, pos_x_i, pos_y_i, color_i
//   out         out        out_valid_o & ready    pixel_o, last_of_frame_o
//
// A write passes S_MUL1, S_MUL2 and S_MEM before the next transfer. A write runs an address
// multiply, a linear address multiply and the store access; a read skips the first and
// then moves the stored word into the output register in S_RESP.
// A clear writes one store entry per cycle over the effective fb_width * fb_height area.
// After reset or a size register change, the first read waits while the shared divider
// derives the resample steps and start positions; no clearing pass runs at reset.
// A result waits in the output register; a following read stalls only if it is still full.
`timescale 1ns / 1ps

module framebuffer_scaled_readout #(
  parameter int unsigned MAX_WIDTH  = fbsr_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = fbsr_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [fbsr_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [fbsr_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [fbsr_pkg::CMD_W-1:0]            command_i,
  input  logic signed [fbsr_pkg::POS_W-1:0]     pos_x_i,
  input  logic signed [fbsr_pkg::POS_W-1:0]     pos_y_i,
  input  logic [fbsr_pkg::COLOR_W-1:0]          color_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [fbsr_pkg::COLOR_W-1:0]          pixel_o,
  output logic                                  last_of_frame_o
);

  import fbsr_pkg::*;

  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned DVW   = CNT_W + ((WW > HW) ? WW : HW);
  localparam int unsigned TopW  = (MAX_WIDTH / 2) * 2;
  localparam int unsigned TopH  = (MAX_HEIGHT / 2) * 2;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL1  = 7'b0000010,
    S_MUL2  = 7'b0000100,
    S_MEM   = 7'b0001000,
    S_RESP  = 7'b0010000,
    S_CLEAR = 7'b0100000,
    S_DIV   = 7'b1000000
  } state_e;

  typedef enum logic [1:0] {
    DIV_COL_STEP = 2'd0,
    DIV_ROW_STEP = 2'd1,
    DIV_COL_POS  = 2'd2,
    DIV_ROW_POS  = 2'd3
  } div_sel_e;

  // Even size clamped to [2, top].
  function automatic logic [SIZE_W-1:0] buf_size(input logic [SIZE_W-1:0] v,
                                                 input int unsigned top);
    logic [SIZE_W-1:0] even;
    even = {v[SIZE_W-1:1], 1'b0};
    if (even < SIZE_W'(2)) begin
      return SIZE_W'(2);
    end else if (32'(even) > top) begin
      return SIZE_W'(top);
    end
    return even;
  endfunction

  function automatic logic [SIZE_W-1:0] out_size(input logic [SIZE_W-1:0] v);
    if (v == '0) begin
      return SIZE_W'(1);
    end else if (32'(v) > OUT_SIZE_MAX) begin
      return SIZE_W'(OUT_SIZE_MAX);
    end
    return v;
  endfunction

  state_e   state_q, state_d;
  div_sel_e div_sel_q, div_sel_d;
  logic     div_run_q, div_run_d;
  logic     dirty_q, dirty_d;
  logic     op_read_q, op_read_d;
  logic     out_valid_q, out_valid_d;

  logic [SIZE_W-1:0]  fbw_q, fbw_d, fbh_q, fbh_d, ow_q, ow_d, oh_q, oh_d;
  logic [COLOR_W-1:0] clear_color_q, clear_color_d;
  logic               swap_q, swap_d;

  logic [CNT_W-1:0]  out_col_q, out_col_d, out_row_q, out_row_d;
  logic [CW-1:0]     colq_q, colq_d;
  logic [SIZE_W-1:0] colr_q, colr_d;
  logic [RW-1:0]     rowq_q, rowq_d;
  logic [SIZE_W-1:0] rowr_q, rowr_d;
  logic [WW-1:0]     qw_q, qw_d;
  logic [SIZE_W-1:0] rw_q, rw_d;
  logic [HW-1:0]     qh_q, qh_d;
  logic [SIZE_W-1:0] rh_q, rh_d;

  logic [POS_W-1:0]   ux_q, ux_d, uy_q, uy_d;
  logic [COLOR_W-1:0] color_q, color_d;
  logic [CW-1:0]      col_idx_q, col_idx_d;
  logic [RW-1:0]      row_idx_q, row_idx_d;
  logic [AW-1:0]      addr_q, addr_d;
  logic               last_pend_q, last_pend_d;
  logic [AW-1:0]      clr_addr_q, clr_addr_d;
  logic [CW-1:0]      clr_col_q, clr_col_d;
  logic [RW-1:0]      clr_row_q, clr_row_d;
  logic [COLOR_W-1:0] pixel_q, pixel_d;
  logic               last_q, last_d;

  logic [WW-1:0]     w_eff;
  logic [HW-1:0]     h_eff;
  logic [SIZE_W-1:0] ow_eff, oh_eff;

  logic              accept, load;
  logic              col_end, row_end;
  logic [SIZE_W:0]   col_rsum, row_rdiff;
  logic              col_carry, row_borrow;
  logic [CW-1:0]     colq_next;
  logic [SIZE_W-1:0] colr_next;
  logic [RW-1:0]     rowq_next, rowq_init;
  logic [SIZE_W-1:0] rowr_next, rowr_init;
  logic [WW:0]       colq_sum;
  logic [HW:0]       rowq_diff, rowq_init_w;

  logic [CNT_W-1:0]      col_cl, row_cl, k_row;
  logic [CNT_W+WW-1:0]   col_prod;
  logic [CNT_W+HW-1:0]   row_prod;
  logic [POS_W+WW-2:0]   px_prod;
  logic [POS_W+HW-2:0]   py_prod;
  logic [RW+WW-1:0]      lin_addr;

  logic              div_start, div_done;
  logic [DVW-1:0]    div_dividend, div_quot;
  logic [SIZE_W-1:0] div_divisor, div_rem;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [COLOR_W-1:0] ram_wdata, ram_rdata;

  assign w_eff  = WW'(buf_size(fbw_q, TopW));
  assign h_eff  = HW'(buf_size(fbh_q, TopH));
  assign ow_eff = out_size(ow_q);
  assign oh_eff = out_size(oh_q);

  // Column source position advances by w/ow per output column.
  assign col_rsum  = {1'b0, colr_q} + {1'b0, rw_q};
  assign col_carry = (col_rsum >= {1'b0, ow_eff});
  assign colr_next = col_carry ? SIZE_W'(col_rsum - {1'b0, ow_eff}) : col_rsum[SIZE_W-1:0];
  assign colq_sum  = (WW+1)'(colq_q) + (WW+1)'(qw_q) + (WW+1)'(col_carry);
  assign colq_next = CW'(colq_sum);

  // Rows go bottom first, so the source row steps down by h/oh.
  assign row_rdiff  = {1'b0, rowr_q} - {1'b0, rh_q};
  assign row_borrow = row_rdiff[SIZE_W];
  assign rowr_next  = row_borrow ? SIZE_W'(row_rdiff + {1'b0, oh_eff})
                                 : row_rdiff[SIZE_W-1:0];
  assign rowq_diff  = (HW+1)'(rowq_q) - (HW+1)'(qh_q) - (HW+1)'(row_borrow);
  assign rowq_next  = RW'(rowq_diff);

  // Source row of the first output row: (oh-1)*h/oh rebuilt from h/oh.
  assign rowq_init_w = (HW+1)'(h_eff) - (HW+1)'(qh_q) - (HW+1)'(rh_q != '0);
  assign rowq_init   = RW'(rowq_init_w);
  assign rowr_init   = (rh_q != '0) ? SIZE_W'(oh_eff - rh_q) : '0;

  assign col_end = ({1'b0, out_col_q} == ow_eff - SIZE_W'(1));
  assign row_end = ({1'b0, out_row_q} == oh_eff - SIZE_W'(1));

  // Counters left outside the frame by a size change restart at zero.
  assign col_cl   = ({1'b0, out_col_q} >= ow_eff) ? '0 : out_col_q;
  assign row_cl   = ({1'b0, out_row_q} >= oh_eff) ? '0 : out_row_q;
  assign k_row    = CNT_W'(oh_eff - SIZE_W'(1) - {1'b0, row_cl});
  assign col_prod = col_cl * w_eff;
  assign row_prod = k_row * h_eff;

  always_comb begin
    div_dividend = DVW'(w_eff);
    div_divisor  = ow_eff;
    unique case (div_sel_q)
      DIV_COL_STEP: begin
        div_dividend = DVW'(w_eff);
        div_divisor  = ow_eff;
      end
      DIV_ROW_STEP: begin
        div_dividend = DVW'(h_eff);
        div_divisor  = oh_eff;
      end
      DIV_COL_POS: begin
        div_dividend = DVW'(col_prod);
        div_divisor  = ow_eff;
      end
      DIV_ROW_POS: begin
        div_dividend = DVW'(row_prod);
        div_divisor  = oh_eff;
      end
      default: ;
    endcase
  end

  assign px_prod  = ux_q * (WW-1)'(w_eff >> 1);
  assign py_prod  = uy_q * (HW-1)'(h_eff >> 1);
  assign lin_addr = row_idx_q * w_eff + (RW+WW)'(col_idx_q);

  assign in_ready_o = (state_q == S_IDLE) && !(dirty_q && (command_i == CMD_READ));
  assign accept     = in_valid_i && in_ready_o;
  assign load       = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d       = state_q;
    div_sel_d     = div_sel_q;
    div_run_d     = div_run_q;
    dirty_d       = dirty_q;
    op_read_d     = op_read_q;
    fbw_d         = fbw_q;
    fbh_d         = fbh_q;
    ow_d          = ow_q;
    oh_d          = oh_q;
    clear_color_d = clear_color_q;
    swap_d        = swap_q;
    out_col_d     = out_col_q;
    out_row_d     = out_row_q;
    colq_d        = colq_q;
    colr_d        = colr_q;
    rowq_d        = rowq_q;
    rowr_d        = rowr_q;
    qw_d          = qw_q;
    rw_d          = rw_q;
    qh_d          = qh_q;
    rh_d          = rh_q;
    ux_d          = ux_q;
    uy_d          = uy_q;
    color_d       = color_q;
    col_idx_d     = col_idx_q;
    row_idx_d     = row_idx_q;
    addr_d        = addr_q;
    last_pend_d   = last_pend_q;
    clr_addr_d    = clr_addr_q;
    clr_col_d     = clr_col_q;
    clr_row_d     = clr_row_q;
    div_start     = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = addr_q;
    ram_wdata     = color_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (command_i)
            CMD_CLEAR: begin
              clr_addr_d = '0;
              clr_col_d  = '0;
              clr_row_d  = '0;
              state_d    = S_CLEAR;
            end
            CMD_WRITE: begin
              ux_d      = pos_x_i ^ {1'b1, {(POS_W-1){1'b0}}};
              uy_d      = pos_y_i ^ {1'b1, {(POS_W-1){1'b0}}};
              color_d   = color_i;
              op_read_d = 1'b0;
              state_d   = S_MUL1;
            end
            CMD_READ: begin
              op_read_d   = 1'b1;
              col_idx_d   = colq_q;
              row_idx_d   = rowq_q;
              last_pend_d = col_end && row_end;
              if (col_end) begin
                out_col_d = '0;
                colq_d    = '0;
                colr_d    = '0;
                if (row_end) begin
                  out_row_d = '0;
                  rowq_d    = rowq_init;
                  rowr_d    = rowr_init;
                end else begin
                  out_row_d = out_row_q + CNT_W'(1);
                  rowq_d    = rowq_next;
                  rowr_d    = rowr_next;
                end
              end else begin
                out_col_d = out_col_q + CNT_W'(1);
                colq_d    = colq_next;
                colr_d    = colr_next;
              end
              state_d = S_MUL2;
            end
            default: ;
          endcase
        end else if (in_valid_i && dirty_q && (command_i == CMD_READ)) begin
          div_sel_d = DIV_COL_STEP;
          div_run_d = 1'b0;
          state_d   = S_DIV;
        end
      end
      S_MUL1: begin
        col_idx_d = CW'(px_prod >> (POS_W - 1));
        row_idx_d = RW'(py_prod >> (POS_W - 1));
        state_d   = S_MUL2;
      end
      S_MUL2: begin
        addr_d  = AW'(lin_addr);
        state_d = S_MEM;
      end
      S_MEM: begin
        if (op_read_q) begin
          ram_re  = 1'b1;
          state_d = S_RESP;
        end else begin
          ram_we  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_RESP: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      S_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = clear_color_q;
        clr_addr_d = clr_addr_q + AW'(1);
        if (WW'(clr_col_q) == w_eff - WW'(1)) begin
          clr_col_d = '0;
          clr_row_d = clr_row_q + RW'(1);
          if (HW'(clr_row_q) == h_eff - HW'(1)) begin
            state_d = S_IDLE;
          end
        end else begin
          clr_col_d = clr_col_q + CW'(1);
        end
      end
      S_DIV: begin
        if (cfg_we_i) begin
          // Sizes may be changing; start over once the port is quiet.
          div_run_d = 1'b0;
          state_d   = S_IDLE;
        end else if (!div_run_q) begin
          div_start = 1'b1;
          div_run_d = 1'b1;
        end else if (div_done) begin
          div_run_d = 1'b0;
          unique case (div_sel_q)
            DIV_COL_STEP: begin
              qw_d      = WW'(div_quot);
              rw_d      = div_rem;
              div_sel_d = DIV_ROW_STEP;
            end
            DIV_ROW_STEP: begin
              qh_d      = HW'(div_quot);
              rh_d      = div_rem;
              div_sel_d = DIV_COL_POS;
            end
            DIV_COL_POS: begin
              colq_d    = CW'(div_quot);
              colr_d    = div_rem;
              div_sel_d = DIV_ROW_POS;
            end
            DIV_ROW_POS: begin
              rowq_d    = RW'(div_quot);
              rowr_d    = div_rem;
              out_col_d = col_cl;
              out_row_d = row_cl;
              dirty_d   = 1'b0;
              state_d   = S_IDLE;
            end
            default: ;
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FB_WIDTH: begin
          fbw_d   = cfg_data_i[SIZE_W-1:0];
          dirty_d = 1'b1;
        end
        CFG_FB_HEIGHT: begin
          fbh_d   = cfg_data_i[SIZE_W-1:0];
          dirty_d = 1'b1;
        end
        CFG_OUT_WIDTH: begin
          ow_d    = cfg_data_i[SIZE_W-1:0];
          dirty_d = 1'b1;
        end
        CFG_OUT_HEIGHT: begin
          oh_d    = cfg_data_i[SIZE_W-1:0];
          dirty_d = 1'b1;
        end
        CFG_CLEAR: clear_color_d = cfg_data_i[COLOR_W-1:0];
        CFG_SWAP:  swap_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    pixel_d     = pixel_q;
    last_d      = last_q;
    if (load) begin
      out_valid_d = 1'b1;
      last_d      = last_pend_q;
      pixel_d     = swap_q ? {ram_rdata[31:24], ram_rdata[7:0],
                              ram_rdata[15:8], ram_rdata[23:16]}
                           : ram_rdata;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      div_sel_q     <= DIV_COL_STEP;
      div_run_q     <= 1'b0;
      dirty_q       <= 1'b1;
      op_read_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      fbw_q         <= SIZE_RST;
      fbh_q         <= SIZE_RST;
      ow_q          <= SIZE_RST;
      oh_q          <= SIZE_RST;
      clear_color_q <= COLOR_RST;
      swap_q        <= 1'b0;
      out_col_q     <= '0;
      out_row_q     <= '0;
      colq_q        <= '0;
      colr_q        <= '0;
      rowq_q        <= '0;
      rowr_q        <= '0;
      qw_q          <= '0;
      rw_q          <= '0;
      qh_q          <= '0;
      rh_q          <= '0;
    end else begin
      state_q       <= state_d;
      div_sel_q     <= div_sel_d;
      div_run_q     <= div_run_d;
      dirty_q       <= dirty_d;
      op_read_q     <= op_read_d;
      out_valid_q   <= out_valid_d;
      fbw_q         <= fbw_d;
      fbh_q         <= fbh_d;
      ow_q          <= ow_d;
      oh_q          <= oh_d;
      clear_color_q <= clear_color_d;
      swap_q        <= swap_d;
      out_col_q     <= out_col_d;
      out_row_q     <= out_row_d;
      colq_q        <= colq_d;
      colr_q        <= colr_d;
      rowq_q        <= rowq_d;
      rowr_q        <= rowr_d;
      qw_q          <= qw_d;
      rw_q          <= rw_d;
      qh_q          <= qh_d;
      rh_q          <= rh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ux_q        <= ux_d;
    uy_q        <= uy_d;
    color_q     <= color_d;
    col_idx_q   <= col_idx_d;
    row_idx_q   <= row_idx_d;
    addr_q      <= addr_d;
    last_pend_q <= last_pend_d;
    clr_addr_q  <= clr_addr_d;
    clr_col_q   <= clr_col_d;
    clr_row_q   <= clr_row_d;
    pixel_q     <= pixel_d;
    last_q      <= last_d;
  end

  fbsr_div #(
    .DividendW (DVW),
    .DivisorW  (SIZE_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  fbsr_ram #(
    .Width (COLOR_W),
    .Depth (Depth),
    .AddrW (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign pixel_o         = pixel_q;
  assign last_of_frame_o = last_q;

endmodule
